// ===== rtl/assert_macros.svh =====
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== rtl/mccp_pkg.sv =====
`timescale 1ns / 1ps
package mccp_pkg;

   localparam int CODE_W  = 8;
   localparam int COLOR_W = 24;
   localparam int IDX_W   = 3;
   localparam int LUM_W   = 16;
   localparam int RATIO_W = 17;
   localparam int PROD_W  = 2 * RATIO_W;
   localparam int CSR_IDX_W = 3;
   localparam int LUM_LAT = 3;

   localparam int COLOR_REGS = 6;
   localparam logic [CSR_IDX_W-1:0] REG_PALETTE_COUNT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_FIRST   = 3'd1;

   localparam logic [IDX_W-1:0]   PALETTE_COUNT_RESET = 3'd2;
   localparam logic [COLOR_W-1:0] COLOR0_RESET        = 24'hFFFFFF;

   localparam logic [13:0]        W_RED      = 14'd13933;
   localparam logic [15:0]        W_GREEN    = 16'd46871;
   localparam logic [12:0]        W_BLUE     = 13'd4732;
   localparam logic [31:0]        LUM_ROUND  = 32'd32768;
   localparam logic [RATIO_W-1:0] LUM_OFFSET = 17'd3277;

   typedef struct packed {
      logic [LUM_W-1:0]   back_lum;
      logic [RATIO_W-1:0] best_num;
      logic [RATIO_W-1:0] best_den;
      logic [IDX_W-1:0]   best_idx;
      logic [COLOR_W-1:0] best_color;
   } item_type;

   typedef struct packed {
      logic               color_we;
      logic [IDX_W-1:0]   color_entry;
      logic [COLOR_W-1:0] color;
      logic               lum_we;
      logic [IDX_W-1:0]   lum_entry;
      logic [LUM_W-1:0]   lum;
   } cell_wr_type;

   // sRGB decode of one 8-bit code to Q0.16; evaluated at elaboration only.
   function automatic logic [LUM_W-1:0] lin_code_f(input int unsigned code);
      longint unsigned n;
      longint unsigned t;
      longint unsigned s;
      longint unsigned lim;
      longint unsigned v;
      longint unsigned m;
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      if (code <= 10) begin
         return LUM_W'((code * 6553600 + 164730) / 329460);
      end
      n = 1000 * longint'(code) + 14025;
      t = (n << 31) / 269025;
      s = (t * t) >> 31;
      lim = s << 29;
      lo = 0;
      hi = 4096;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         m = longint'(mid);
         if (m * m * m * m * m <= lim) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      v = (s * longint'(lo) + (64'd1 << 26)) >> 27;
      if (v > 65535) begin
         v = 65535;
      end
      return LUM_W'(v);
   endfunction

   function automatic logic [LUM_W-1:0] color_lum_f(input logic [COLOR_W-1:0] rgb);
      longint unsigned acc;
      acc = longint'(W_RED)   * longint'(lin_code_f(int'(rgb[23:16])))
          + longint'(W_GREEN) * longint'(lin_code_f(int'(rgb[15:8])))
          + longint'(W_BLUE)  * longint'(lin_code_f(int'(rgb[7:0])))
          + longint'(LUM_ROUND);
      return LUM_W'(acc >> 16);
   endfunction

endpackage

// ===== rtl/mccp_ifs.sv =====
`timescale 1ns / 1ps
interface mccp_req_if import mccp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] back_red;
   logic [CODE_W-1:0] back_green;
   logic [CODE_W-1:0] back_blue;

   modport source (output valid, output back_red, output back_green, output back_blue,
                   input ready);
   modport sink   (input valid, input back_red, input back_green, input back_blue,
                   output ready);
endinterface

interface mccp_rsp_if import mccp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [IDX_W-1:0]   chosen_index;
   logic [COLOR_W-1:0] chosen_color;

   modport source (output valid, output chosen_index, output chosen_color, input ready);
   modport sink   (input valid, input chosen_index, input chosen_color, output ready);
endinterface

interface mccp_csr_if import mccp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COLOR_W-1:0]   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/max_contrast_color_picker_unit.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Picks, for each background color, the palette entry with the highest contrast
// ratio and returns its index and color. One transaction is taken every clock
// unless the response side stalls. Three stages of luminance (table
// decode, channel weighting, sum) are followed by one two-stage cell per palette
// entry (cross products, then compare and pick). Stages with no transaction
// soak up stalls on the response side. Writing a palette color recomputes its
// luminance in a separate three-stage unit; the value is in place before any
// transaction accepted after the write reaches the cells. The configuration
// port is always ready; out-of-range register indexes are dropped.
module max_contrast_color_picker_unit import mccp_pkg::*; #(
   parameter int MAX_COLORS = 6
) (
   input  logic             clock,
   input  logic             reset,
   mccp_req_if.sink         req_bus,
   mccp_rsp_if.source       rsp_bus,
   mccp_csr_if.sink         csr_bus
);

   logic [IDX_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] cfg_entry_ff [LUM_LAT];
   logic [IDX_W-1:0] cfg_entry_in [LUM_LAT];

   logic               csr_fire, color_we;
   logic [IDX_W-1:0]   color_entry;
   logic               cfg_lum_in_ready, cfg_lum_valid;
   logic [LUM_W-1:0]   cfg_lum;
   logic               bg_lum_valid;
   logic [LUM_W-1:0]   bg_lum;
   cell_wr_type        cell_wr;

   logic     chain_valid [MAX_COLORS+1];
   logic     chain_ready [MAX_COLORS+1];
   item_type chain_item  [MAX_COLORS+1];
   logic     cell_active [MAX_COLORS];

   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;
   assign color_entry   = csr_bus.index - REG_COLOR_FIRST;
   assign color_we      = csr_fire && (csr_bus.index != REG_PALETTE_COUNT)
                          && (csr_bus.index <= CSR_IDX_W'(COLOR_REGS))
                          && (int'(color_entry) < MAX_COLORS);

   always_comb begin
      count_in = count_ff;
      if (csr_fire && (csr_bus.index == REG_PALETTE_COUNT)) begin
         count_in = csr_bus.data[IDX_W-1:0];
      end
      cfg_entry_in[0] = color_entry;
      for (int i = 1; i < LUM_LAT; i++) begin
         cfg_entry_in[i] = cfg_entry_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= PALETTE_COUNT_RESET;
      end else begin
         count_ff <= count_in;
      end
   end

   // entry tag rides alongside the luminance unit, which never stalls here
   always_ff @(posedge clock) begin
      cfg_entry_ff <= cfg_entry_in;
   end

   mccp_lum u_cfg_lum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (color_we),
      .in_ready  (cfg_lum_in_ready),
      .in_rgb    (csr_bus.data),
      .out_valid (cfg_lum_valid),
      .out_ready (1'b1),
      .out_lum   (cfg_lum)
   );

   assign cell_wr.color_we    = color_we;
   assign cell_wr.color_entry = color_entry;
   assign cell_wr.color       = csr_bus.data;
   assign cell_wr.lum_we      = cfg_lum_valid;
   assign cell_wr.lum_entry   = cfg_entry_ff[LUM_LAT-1];
   assign cell_wr.lum         = cfg_lum;

   mccp_lum u_bg_lum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_rgb    ({req_bus.back_red, req_bus.back_green, req_bus.back_blue}),
      .out_valid (bg_lum_valid),
      .out_ready (chain_ready[0]),
      .out_lum   (bg_lum)
   );

   assign chain_valid[0]           = bg_lum_valid;
   assign chain_item[0].back_lum   = bg_lum;
   assign chain_item[0].best_num   = '0;
   assign chain_item[0].best_den   = RATIO_W'(1);
   assign chain_item[0].best_idx   = '0;
   assign chain_item[0].best_color = '0;

   for (genvar k = 0; k < MAX_COLORS; k++) begin : g_cell
      // a count of zero still keeps entry zero in play
      assign cell_active[k] = (k == 0) || (int'(count_ff) > k);

      mccp_cell #(.CELL_IDX(k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .wr        (cell_wr),
         .active    (cell_active[k]),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_item   (chain_item[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_item  (chain_item[k+1])
      );
   end

   assign rsp_bus.valid           = chain_valid[MAX_COLORS];
   assign rsp_bus.chosen_index    = chain_item[MAX_COLORS].best_idx;
   assign rsp_bus.chosen_color    = chain_item[MAX_COLORS].best_color;
   assign chain_ready[MAX_COLORS] = rsp_bus.ready;

   `ASSERT_IMPLIES(cfg_lum_ready_a, clock, reset, color_we, cfg_lum_in_ready)
   `ASSERT_IMPLIES(cfg_lum_lands_a, clock, reset, cfg_lum_valid, $past(color_we, LUM_LAT))
   `ASSERT_IMPLIES(index_in_range_a, clock, reset, rsp_bus.valid, int'(rsp_bus.chosen_index) < MAX_COLORS)

endmodule

// ===== rtl/mccp_lum.sv =====
`timescale 1ns / 1ps
// Three-stage relative luminance: table decode, weight, sum and round.
module mccp_lum import mccp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [COLOR_W-1:0] in_rgb,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [LUM_W-1:0]   out_lum
);

   localparam int TABLE_DEPTH = 2 ** CODE_W;

   logic [LUM_W-1:0] lin_rom [TABLE_DEPTH];

   for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_rom
      localparam logic [LUM_W-1:0] LinVal = lin_code_f(k);
      assign lin_rom[k] = LinVal;
   end

   logic             v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic [LUM_W-1:0] lr_ff, lr_in, lg_ff, lg_in, lb_ff, lb_in;
   logic [29:0]      pr_ff, pr_in;
   logic [31:0]      pg_ff, pg_in;
   logic [28:0]      pb_ff, pb_in;
   logic [LUM_W-1:0] lum_ff, lum_in;
   logic [31:0]      sum;
   logic             rdy1, rdy2, rdy3;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   assign sum = 32'(pr_ff) + pg_ff + 32'(pb_ff) + LUM_ROUND;

   always_comb begin
      v1_in  = rdy1 ? in_valid : v1_ff;
      v2_in  = rdy2 ? v1_ff : v2_ff;
      v3_in  = rdy3 ? v2_ff : v3_ff;
      lr_in  = lr_ff;
      lg_in  = lg_ff;
      lb_in  = lb_ff;
      pr_in  = pr_ff;
      pg_in  = pg_ff;
      pb_in  = pb_ff;
      lum_in = lum_ff;
      if (in_valid && rdy1) begin
         lr_in = lin_rom[in_rgb[23:16]];
         lg_in = lin_rom[in_rgb[15:8]];
         lb_in = lin_rom[in_rgb[7:0]];
      end
      if (v1_ff && rdy2) begin
         pr_in = 30'(lr_ff) * 30'(W_RED);
         pg_in = 32'(lg_ff) * 32'(W_GREEN);
         pb_in = 29'(lb_ff) * 29'(W_BLUE);
      end
      if (v2_ff && rdy3) begin
         lum_in = sum[31:16];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      lr_ff  <= lr_in;
      lg_ff  <= lg_in;
      lb_ff  <= lb_in;
      pr_ff  <= pr_in;
      pg_ff  <= pg_in;
      pb_ff  <= pb_in;
      lum_ff <= lum_in;
   end

   assign out_valid = v3_ff;
   assign out_lum   = lum_ff;

endmodule

// ===== rtl/mccp_cell.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// One palette entry: holds its color and luminance, compares the passing
// transaction's best ratio against its own and hands the winner on.
module mccp_cell import mccp_pkg::*; #(
   parameter int CELL_IDX = 0
) (
   input  logic        clock,
   input  logic        reset,
   input  cell_wr_type wr,
   input  logic        active,
   input  logic        in_valid,
   output logic        in_ready,
   input  item_type    in_item,
   output logic        out_valid,
   input  logic        out_ready,
   output item_type    out_item
);

   localparam logic [IDX_W-1:0]   IDX       = IDX_W'(CELL_IDX);
   localparam logic               IS_FIRST  = (CELL_IDX == 0);
   localparam logic [COLOR_W-1:0] COLOR_RST = IS_FIRST ? COLOR0_RESET : '0;
   localparam logic [LUM_W-1:0]   LUM_RST   = color_lum_f(COLOR_RST);

   logic [COLOR_W-1:0] color_ff, color_in;
   logic [LUM_W-1:0]   lum_ff, lum_in;

   logic               a_valid_ff, a_valid_in, b_valid_ff, b_valid_in;
   item_type           a_item_ff, a_item_in, b_item_ff, b_item_in;
   logic [RATIO_W-1:0] a_num_ff, a_num_in, a_den_ff, a_den_in;
   logic [PROD_W-1:0]  a_lhs_ff, a_lhs_in, a_rhs_ff, a_rhs_in;

   logic               a_ready, b_ready, take;
   logic [LUM_W-1:0]   hi_l, lo_l;
   logic [RATIO_W-1:0] num_c, den_c;

   assign b_ready  = !b_valid_ff || out_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign in_ready = a_ready;

   assign hi_l  = (lum_ff > in_item.back_lum) ? lum_ff : in_item.back_lum;
   assign lo_l  = (lum_ff > in_item.back_lum) ? in_item.back_lum : lum_ff;
   assign num_c = RATIO_W'(hi_l) + LUM_OFFSET;
   assign den_c = RATIO_W'(lo_l) + LUM_OFFSET;

   // strictly larger ratio only, so the lower index keeps a tie
   assign take = active && (IS_FIRST || (a_lhs_ff > a_rhs_ff));

   always_comb begin
      color_in = color_ff;
      lum_in   = lum_ff;
      if (wr.color_we && (wr.color_entry == IDX)) begin
         color_in = wr.color;
      end
      if (wr.lum_we && (wr.lum_entry == IDX)) begin
         lum_in = wr.lum;
      end
   end

   always_comb begin
      a_valid_in = a_ready ? in_valid : a_valid_ff;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      a_item_in  = a_item_ff;
      a_num_in   = a_num_ff;
      a_den_in   = a_den_ff;
      a_lhs_in   = a_lhs_ff;
      a_rhs_in   = a_rhs_ff;
      b_item_in  = b_item_ff;
      if (in_valid && a_ready) begin
         a_item_in = in_item;
         a_num_in  = num_c;
         a_den_in  = den_c;
         a_lhs_in  = PROD_W'(num_c) * PROD_W'(in_item.best_den);
         a_rhs_in  = PROD_W'(in_item.best_num) * PROD_W'(den_c);
      end
      if (a_valid_ff && b_ready) begin
         b_item_in = a_item_ff;
         if (take) begin
            b_item_in.best_num   = a_num_ff;
            b_item_in.best_den   = a_den_ff;
            b_item_in.best_idx   = IDX;
            b_item_in.best_color = color_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff   <= COLOR_RST;
         lum_ff     <= LUM_RST;
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         color_ff   <= color_in;
         lum_ff     <= lum_in;
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_item_ff <= a_item_in;
      a_num_ff  <= a_num_in;
      a_den_ff  <= a_den_in;
      a_lhs_ff  <= a_lhs_in;
      a_rhs_ff  <= a_rhs_in;
      b_item_ff <= b_item_in;
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

   `ASSERT_NEXT(first_cell_wins_a, clock, reset, IS_FIRST && a_valid_ff && b_ready, b_item_ff.best_idx == IDX)
   `ASSERT_NEXT(idle_cell_keeps_best_a, clock, reset, !active && a_valid_ff && b_ready, b_item_ff.best_idx == $past(a_item_ff.best_idx))
   `ASSERT_NEXT(tie_keeps_lower_a, clock, reset, !IS_FIRST && a_valid_ff && b_ready && (a_lhs_ff == a_rhs_ff), b_item_ff.best_idx == $past(a_item_ff.best_idx))
   `ASSERT_NEXT(stalled_out_holds_a, clock, reset, b_valid_ff && !out_ready, b_valid_ff && $stable(b_item_ff))

endmodule
